@@ hdl/dwc_pkg.sv @@
`timescale 1ns / 1ps
package dwc_pkg;

   localparam int WORD_W = 32;
   localparam int CMD_W  = 3;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_LEFT    = 3'd0,
      CMD_PUSH_RIGHT   = 3'd1,
      CMD_POP_LEFT     = 3'd2,
      CMD_POP_RIGHT    = 3'd3,
      CMD_CURSOR_LEFT  = 3'd4,
      CMD_CURSOR_RIGHT = 3'd5,
      CMD_SET_CURSOR   = 3'd6,
      CMD_QUERY        = 3'd7
   } cmd_type;

   // per-item flags from the controller to the result path
   typedef struct packed {
      logic moved;
      logic error;
      logic took_left;
      logic took_right;
   } status_type;

endpackage

@@ hdl/dwc_ram.sv @@
`timescale 1ns / 1ps
module dwc_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/dwc_rport.sv @@
`timescale 1ns / 1ps
module dwc_rport #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [dwc_pkg::WORD_W-1:0]    wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [dwc_pkg::WORD_W-1:0]    word
);
   import dwc_pkg::*;

   logic              byp_ff, byp_in;
   logic [WORD_W-1:0] byp_data_ff;
   logic [WORD_W-1:0] ram_data;

   dwc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_data)
   );

   // the RAM reads old data on a same-cycle write: forward the new word
   assign byp_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         byp_ff <= 1'b0;
      end else if (rd_en) begin
         byp_ff <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         byp_data_ff <= wr_data;
      end
   end

   assign word = byp_ff ? byp_data_ff : ram_data;

endmodule

@@ hdl/dwc_ctrl.sv @@
`timescale 1ns / 1ps
module dwc_ctrl #(
   parameter int DEPTH = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [dwc_pkg::CMD_W-1:0]        command,
   input  logic [dwc_pkg::WORD_W-1:0]       value,
   output dwc_pkg::status_type              status,
   output logic [$clog2(DEPTH+1)-1:0]       count_next,
   output logic                             wr_en,
   output logic [$clog2(DEPTH)-1:0]         wr_addr,
   output logic [dwc_pkg::WORD_W-1:0]       wr_data,
   output logic [$clog2(DEPTH)-1:0]         rd_left,
   output logic [$clog2(DEPTH)-1:0]         rd_right,
   output logic [$clog2(DEPTH)-1:0]         rd_cursor
);
   import dwc_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [IDX_W:0]   DEPTH_X  = DEPTH[IDX_W:0];
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);
   localparam logic [IDX_W-1:0] ONE_IDX  = IDX_W'(1);

   logic [IDX_W-1:0] left_ff, left_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] cur_ff, cur_in;

   logic [CNT_W-1:0] fill_dec, fill_in_dec, cur_ext;
   logic [CNT_W-1:0] fill_in_m1;
   logic [IDX_W-1:0] right_off, right_off_in;
   logic             empty, full;
   logic             wr_req;
   cmd_type          cmd;

   // ring position off places right of base
   function automatic logic [IDX_W-1:0] slot(input logic [IDX_W-1:0] base,
                                             input logic [IDX_W-1:0] off);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_X) begin
         sum = sum - DEPTH_X;
      end
      return sum[IDX_W-1:0];
   endfunction

   assign cmd      = cmd_type'(command);
   assign empty    = (fill_ff == '0);
   assign full     = (fill_ff == FULL_CNT);
   assign fill_dec = fill_ff - ONE_CNT;
   assign cur_ext  = CNT_W'(cur_ff);
   assign right_off = empty ? '0 : fill_dec[IDX_W-1:0];

   always_comb begin
      left_in = left_ff;
      fill_in = fill_ff;
      cur_in  = cur_ff;
      status  = '0;
      wr_req  = 1'b0;
      wr_addr = slot(left_ff, cur_ff);
      fill_in_dec = fill_dec - ONE_CNT;
      case (cmd)
         CMD_PUSH_LEFT: begin
            if (full) begin
               status.error = 1'b1;
            end else begin
               left_in = (left_ff == '0) ? LAST_IDX : left_ff - ONE_IDX;
               wr_req  = 1'b1;
               wr_addr = left_in;
               cur_in  = empty ? '0 : cur_ff + ONE_IDX;
               fill_in = fill_ff + ONE_CNT;
            end
         end
         CMD_PUSH_RIGHT: begin
            if (full) begin
               status.error = 1'b1;
            end else begin
               wr_req  = 1'b1;
               wr_addr = slot(left_ff, fill_ff[IDX_W-1:0]);
               cur_in  = empty ? '0 : cur_ff;
               fill_in = fill_ff + ONE_CNT;
            end
         end
         CMD_POP_LEFT: begin
            if (empty) begin
               status.error = 1'b1;
            end else begin
               status.took_left = 1'b1;
               left_in = (left_ff == LAST_IDX) ? '0 : left_ff + ONE_IDX;
               fill_in = fill_dec;
               cur_in  = (fill_dec == '0 || cur_ff == '0) ? '0 : cur_ff - ONE_IDX;
            end
         end
         CMD_POP_RIGHT: begin
            if (empty) begin
               status.error = 1'b1;
            end else begin
               status.took_right = 1'b1;
               fill_in = fill_dec;
               if (fill_dec == '0) begin
                  cur_in = '0;
               end else if (cur_ext >= fill_dec) begin
                  cur_in = fill_in_dec[IDX_W-1:0];
               end
            end
         end
         CMD_CURSOR_LEFT: begin
            if (empty) begin
               status.error = 1'b1;
            end else if (cur_ff != '0) begin
               cur_in = cur_ff - ONE_IDX;
               status.moved = 1'b1;
            end
         end
         CMD_CURSOR_RIGHT: begin
            if (empty) begin
               status.error = 1'b1;
            end else if ((cur_ext + ONE_CNT) < fill_ff) begin
               cur_in = cur_ff + ONE_IDX;
               status.moved = 1'b1;
            end
         end
         CMD_SET_CURSOR: begin
            if (empty) begin
               status.error = 1'b1;
            end else begin
               wr_req = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // read the end and cursor words of the state after this item
   assign fill_in_m1   = fill_in - ONE_CNT;
   assign right_off_in = (fill_in == '0) ? '0 : fill_in_m1[IDX_W-1:0];

   assign rd_left    = left_in;
   assign rd_right   = slot(left_in, right_off_in);
   assign rd_cursor  = slot(left_in, cur_in);
   assign wr_en      = accept && wr_req;
   assign wr_data    = value;
   assign count_next = fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
         fill_ff <= '0;
         cur_ff  <= '0;
      end else if (accept) begin
         left_ff <= left_in;
         fill_ff <= fill_in;
         cur_ff  <= cur_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_CNT)
      else $error("fill count above depth");

   a_cursor_inside: assert property (@(posedge clock) disable iff (reset)
      !empty |-> cur_ext < fill_ff)
      else $error("cursor outside occupied range");

   a_empty_cursor: assert property (@(posedge clock) disable iff (reset)
      empty |-> cur_ff == '0)
      else $error("cursor not at zero on empty deque");

   a_right_off: assert property (@(posedge clock) disable iff (reset)
      !empty |-> CNT_W'(right_off) == fill_dec)
      else $error("right offset mismatch");

endmodule

@@ hdl/deque_with_cursor.sv @@
`timescale 1ns / 1ps
// An accepted item is registered in s1, then in the result registers behind rsp_valid.
// One item per cycle unless stalled; each ring memory takes one write and one read.
// Three RAM copies serve the left, right and cursor words of the state after each item.
// Reset clears the end index, fill count, cursor and all valid flags.
// Entries are not cleared and need no clearing pass: only written entries are read.
module deque_with_cursor #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [dwc_pkg::CMD_W-1:0]         req_command,
   input  logic signed [dwc_pkg::WORD_W-1:0] req_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [dwc_pkg::WORD_W-1:0] rsp_popped_word,
   output logic                              rsp_moved,
   output logic                              rsp_error,
   output logic [$clog2(DEPTH+1)-1:0]        rsp_count,
   output logic                              rsp_is_empty,
   output logic signed [dwc_pkg::WORD_W-1:0] rsp_left_word,
   output logic signed [dwc_pkg::WORD_W-1:0] rsp_right_word,
   output logic signed [dwc_pkg::WORD_W-1:0] rsp_cursor_word
);
   import dwc_pkg::*;

   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic               accept, out_ready;
   status_type         status;
   logic [CNT_W-1:0]   count_next;
   logic               wr_en;
   logic [IDX_W-1:0]   wr_addr, rd_left, rd_right, rd_cursor;
   logic [WORD_W-1:0]  wr_data, left_word, right_word, cursor_word;
   logic [WORD_W-1:0]  popped_in;

   logic               s1_valid_ff, s1_valid_in;
   status_type         s1_status_ff;
   logic [CNT_W-1:0]   s1_count_ff;
   logic [WORD_W-1:0]  s1_popped_ff;
   logic               s1_empty;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]  rsp_popped_ff, rsp_left_ff, rsp_right_ff, rsp_cursor_ff;
   logic               rsp_moved_ff, rsp_error_ff, rsp_empty_ff;
   logic [CNT_W-1:0]   rsp_count_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !out_ready;
   assign accept    = req_valid && !req_stall;

   dwc_ctrl #(.DEPTH(DEPTH)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .command    (req_command),
      .value      (req_value),
      .status     (status),
      .count_next (count_next),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .rd_left    (rd_left),
      .rd_right   (rd_right),
      .rd_cursor  (rd_cursor)
   );

   dwc_rport #(.DEPTH(DEPTH)) u_left (
      .clock (clock), .reset (reset),
      .wr_en (wr_en), .wr_addr (wr_addr), .wr_data (wr_data),
      .rd_en (accept), .rd_addr (rd_left), .word (left_word)
   );

   dwc_rport #(.DEPTH(DEPTH)) u_right (
      .clock (clock), .reset (reset),
      .wr_en (wr_en), .wr_addr (wr_addr), .wr_data (wr_data),
      .rd_en (accept), .rd_addr (rd_right), .word (right_word)
   );

   dwc_rport #(.DEPTH(DEPTH)) u_cursor (
      .clock (clock), .reset (reset),
      .wr_en (wr_en), .wr_addr (wr_addr), .wr_data (wr_data),
      .rd_en (accept), .rd_addr (rd_cursor), .word (cursor_word)
   );

   // port words still hold the ends of the state before this item
   always_comb begin
      if (status.took_left) begin
         popped_in = left_word;
      end else if (status.took_right) begin
         popped_in = right_word;
      end else begin
         popped_in = '0;
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   assign rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
   assign s1_empty     = (s1_count_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status;
         s1_count_ff  <= count_next;
         s1_popped_ff <= popped_in;
      end
      // hand the item on while the RAM words still belong to it
      if (s1_valid_ff && out_ready) begin
         rsp_popped_ff <= s1_popped_ff;
         rsp_moved_ff  <= s1_status_ff.moved;
         rsp_error_ff  <= s1_status_ff.error;
         rsp_count_ff  <= s1_count_ff;
         rsp_empty_ff  <= s1_empty;
         rsp_left_ff   <= s1_empty ? '0 : left_word;
         rsp_right_ff  <= s1_empty ? '0 : right_word;
         rsp_cursor_ff <= s1_empty ? '0 : cursor_word;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_popped_word = rsp_popped_ff;
   assign rsp_moved       = rsp_moved_ff;
   assign rsp_error       = rsp_error_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_left_word   = rsp_left_ff;
   assign rsp_right_word  = rsp_right_ff;
   assign rsp_cursor_word = rsp_cursor_ff;

   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && rsp_stall |-> !accept)
      else $error("item accepted while result path is blocked");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_count == '0)))
      else $error("empty flag disagrees with count");

   a_moved_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_moved && rsp_error))
      else $error("moved and error both set");

   a_error_no_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_popped_word == '0)
      else $error("popped word on refused item");

   a_empty_words: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_empty |-> rsp_left_word == '0 && rsp_cursor_word == '0)
      else $error("words not zero on empty deque");

endmodule
